FILE: hw/rtl/ctsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctsf_pkg
// Shared types and constants for the capacitive touch sense filter.
// ----------------------------------------------------------------------------
package ctsf_pkg;

  localparam int unsigned RING_DEPTH_DEF = 16;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned TRIM_COUNT     = 5;
  localparam int unsigned SUM_W          = 19;  // 5 * 0xFFFF fits
  localparam int unsigned DIV5_MUL_W     = 20;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 20'd838861;  // ceil(2^22 / 5)
  localparam int unsigned DIV5_SHIFT     = 22;

  localparam int unsigned DTICK_W  = 8;
  localparam int unsigned PERIOD_W = 10;

  localparam logic [DTICK_W-1:0]  DISCHARGE_RST = 8'd10;
  localparam logic [DTICK_W-1:0]  MEASURE_RST   = 8'd20;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 10'd50;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 16'd4400;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISCHARGE = 2'd0,
    CFG_MEASURE   = 2'd1,
    CFG_PERIOD    = 2'd2,
    CFG_THRESHOLD = 2'd3
  } ctsf_cfg_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_DISCH = 2'd1,
    PH_MEAS  = 2'd2
  } ctsf_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_FILT = 2'd1,
    ST_PEND = 2'd2
  } ctsf_ctl_e;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_KEY  = 2'd1,
    F_KEYW = 2'd2,
    F_SCAN = 2'd3
  } ctsf_filt_e;

  // Ring write and filter start from the sequencer.
  typedef struct packed {
    logic                wr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                start;
  } ctsf_ring_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ctsf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctsf_if
// Valid/ready channels for tick/capture input and per-step results.
// ----------------------------------------------------------------------------
interface ctsf_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] capture_value;

  modport source (output valid, output func, output capture_value, input ready);
  modport sink   (input valid, input func, input capture_value, output ready);
endinterface

interface ctsf_out_if;
  logic        valid;
  logic        ready;
  logic        touched;
  logic [15:0] filtered_value;
  logic        pin_floating;
  logic        timer_clear;
  logic        sample_stored;

  modport source (output valid, output touched, output filtered_value,
                  output pin_floating, output timer_clear, output sample_stored,
                  input ready);
  modport sink   (input valid, input touched, input filtered_value,
                  input pin_floating, input timer_clear, input sample_stored,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/capacitive_touch_sense_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capacitive_touch_sense_filter_core
// Pad sequencer (discharge / measure / store) with a trimmed-mean filter.
// ----------------------------------------------------------------------------
// Timing: a plain step's result is in the output register the cycle after
//   the input transfer; a filter update step first runs the rank sweep,
//   one key read plus one read per compare through the single RAM port.
// Throughput: one item in flight; up to one transfer per cycle while the
//   output drains, input held off for the whole filter update.
// Reset: async active low; defaults restored, ring reads as zero via valid bits.
// ----------------------------------------------------------------------------
module capacitive_touch_sense_filter_core #(
  parameter int unsigned RING_DEPTH = ctsf_pkg::RING_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  ctsf_in_if.sink                                in_ch,
  ctsf_out_if.source                             out_ch,
  input  wire logic                              cfg_we_i,
  input  wire logic [ctsf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ctsf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ctsf_pkg::*;

  // Configuration registers
  logic [DTICK_W-1:0]  discharge_q, measure_q;
  logic [PERIOD_W-1:0] period_q;
  logic [SAMPLE_W-1:0] thresh_q;

  // Sequencer state
  ctsf_ctl_e           st_q, st_d;
  ctsf_phase_e         phase_q, phase_d;
  logic [DTICK_W-1:0]  pticks_q, pticks_d, pt;
  logic [PERIOD_W-1:0] fticks_q, fticks_d, ft;
  logic                measuring_q, measuring_d;
  logic                pin_float_q, pin_float_d;
  logic [SAMPLE_W-1:0] filtered_q, filtered_d;

  // Step flags kept while the filter runs
  logic                tclr_q, tclr_d;
  logic                stored_q, stored_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic                out_touched_q, out_touched_d;
  logic [SAMPLE_W-1:0] out_filt_q, out_filt_d;
  logic                out_pin_q, out_pin_d;
  logic                out_tclr_q, out_tclr_d;
  logic                out_stored_q, out_stored_d;

  logic                accept, slot_free, load, recompute;
  logic [SAMPLE_W-1:0] load_val;

  ctsf_ring_ctl_t      ring_ctl;
  logic                filt_done;
  logic [SAMPLE_W-1:0] filt_value;

  ctsf_rank_filter #(
    .RING_DEPTH (RING_DEPTH)
  ) u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ring_ctl),
    .done_o  (filt_done),
    .value_o (filt_value)
  );

  // Output slot is free if empty or its transfer completes this cycle.
  assign slot_free    = !out_valid_q || out_ch.ready;
  assign in_ch.ready  = (st_q == ST_IDLE) && slot_free;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    pticks_d    = pticks_q;
    fticks_d    = fticks_q;
    measuring_d = measuring_q;
    pin_float_d = pin_float_q;
    filtered_d  = filtered_q;
    tclr_d      = tclr_q;
    stored_d    = stored_q;
    pt          = pticks_q;
    ft          = fticks_q;
    recompute   = 1'b0;
    load        = 1'b0;
    load_val    = filtered_q;
    ring_ctl.wr      = 1'b0;
    ring_ctl.wr_data = in_ch.capture_value;
    ring_ctl.start   = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          tclr_d   = 1'b0;
          stored_d = 1'b0;
          if (in_ch.func) begin
            // Capture: only counts while measuring, no counter moves.
            if (measuring_q) begin
              ring_ctl.wr = 1'b1;
              stored_d    = 1'b1;
              measuring_d = 1'b0;
              phase_d     = PH_START;
            end
          end else begin
            case (phase_q)
              PH_START: begin
                pt          = '0;
                pin_float_d = 1'b0;
                phase_d     = PH_DISCH;
              end
              PH_DISCH: begin
                if (pticks_q >= discharge_q) begin
                  pin_float_d = 1'b1;
                  tclr_d      = 1'b1;
                  pt          = '0;
                  measuring_d = 1'b1;
                  phase_d     = PH_MEAS;
                end
              end
              PH_MEAS: begin
                if (pticks_q >= measure_q) begin
                  ring_ctl.wr = 1'b1;
                  stored_d    = 1'b1;
                  measuring_d = 1'b0;
                  phase_d     = PH_START;
                end
              end
              default: begin
                // unused phase code recovers to start
                measuring_d = 1'b0;
                phase_d     = PH_START;
              end
            endcase
            // saturating counters
            pticks_d = (pt != '1) ? pt + 1'b1 : pt;
            ft       = (fticks_q != '1) ? fticks_q + 1'b1 : fticks_q;
            if (ft >= period_q) begin
              ft        = '0;
              recompute = 1'b1;
            end
            fticks_d = ft;
          end
          ring_ctl.start = recompute;
          if (recompute) begin
            st_d = ST_FILT;
          end else begin
            load = 1'b1;
          end
        end
      end
      ST_FILT: begin
        if (filt_done) begin
          filtered_d = filt_value;
          load_val   = filt_value;
          if (slot_free) begin
            load = 1'b1;
            st_d = ST_IDLE;
          end else begin
            st_d = ST_PEND;
          end
        end
      end
      ST_PEND: begin
        if (slot_free) begin
          load = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    out_valid_d  = out_valid_q && !out_ch.ready;
    out_touched_d = out_touched_q;
    out_filt_d    = out_filt_q;
    out_pin_d     = out_pin_q;
    out_tclr_d    = out_tclr_q;
    out_stored_d  = out_stored_q;
    if (load) begin
      out_valid_d   = 1'b1;
      out_touched_d = load_val > thresh_q;
      out_filt_d    = load_val;
      out_pin_d     = pin_float_d;
      out_tclr_d    = tclr_d;
      out_stored_d  = stored_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discharge_q <= DISCHARGE_RST;
      measure_q   <= MEASURE_RST;
      period_q    <= PERIOD_RST;
      thresh_q    <= THRESHOLD_RST;
      st_q        <= ST_IDLE;
      phase_q     <= PH_START;
      pticks_q    <= '0;
      fticks_q    <= '0;
      measuring_q <= 1'b0;
      pin_float_q <= 1'b0;
      filtered_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (ctsf_cfg_e'(cfg_idx_i))
          CFG_DISCHARGE: discharge_q <= cfg_data_i[DTICK_W-1:0];
          CFG_MEASURE:   measure_q   <= cfg_data_i[DTICK_W-1:0];
          CFG_PERIOD:    period_q    <= cfg_data_i[PERIOD_W-1:0];
          CFG_THRESHOLD: thresh_q    <= cfg_data_i[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      st_q        <= st_d;
      phase_q     <= phase_d;
      pticks_q    <= pticks_d;
      fticks_q    <= fticks_d;
      measuring_q <= measuring_d;
      pin_float_q <= pin_float_d;
      filtered_q  <= filtered_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tclr_q        <= tclr_d;
    stored_q      <= stored_d;
    out_touched_q <= out_touched_d;
    out_filt_q    <= out_filt_d;
    out_pin_q     <= out_pin_d;
    out_tclr_q    <= out_tclr_d;
    out_stored_q  <= out_stored_d;
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.touched        = out_touched_q;
  assign out_ch.filtered_value = out_filt_q;
  assign out_ch.pin_floating   = out_pin_q;
  assign out_ch.timer_clear    = out_tclr_q;
  assign out_ch.sample_stored  = out_stored_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ctsf_rank_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctsf_rank_filter
// Sample ring in a synchronous RAM plus a rank sweep that sums the middle
// five order statistics and divides by five.
// ----------------------------------------------------------------------------
module ctsf_rank_filter #(
  parameter int unsigned RING_DEPTH = ctsf_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ctsf_pkg::ctsf_ring_ctl_t      ctl_i,
  output logic                               done_o,
  output logic [ctsf_pkg::SAMPLE_W-1:0]      value_o
);
  import ctsf_pkg::*;

  localparam int unsigned IW     = $clog2(RING_DEPTH);
  localparam int unsigned PROD_W = SUM_W + DIV5_MUL_W;
  localparam logic [IW-1:0] LAST    = IW'(RING_DEPTH - 1);
  localparam logic [IW-1:0] RANK_LO = IW'(RING_DEPTH / 2 - 2);
  localparam logic [IW-1:0] RANK_HI = IW'(RING_DEPTH / 2 + 2);

  logic [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_q;
  logic [IW-1:0]       widx_q, widx_d;

  logic [IW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                rd_vld_q;
  logic [SAMPLE_W-1:0] rd_val;

  ctsf_filt_e          fst_q, fst_d;
  logic [IW-1:0]       outer_q, outer_d;
  logic [IW-1:0]       cmp_q, cmp_d;
  logic [IW-1:0]       rank_q, rank_d, rank_fin;
  logic [SAMPLE_W-1:0] key_q, key_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                div_q, div_d;
  logic                done_q;
  logic [SAMPLE_W-1:0] value_q;
  logic [PROD_W-1:0]   prod;
  logic                less;

  // RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[widx_q] <= ctl_i.wr_data;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= valid_q[rd_addr];
  end

  assign rd_val = rd_vld_q ? rd_data_q : '0;
  assign widx_d = (widx_q == LAST) ? '0 : widx_q + 1'b1;

  // Stable tie-break by index gives each entry a unique sorted position.
  assign less = (rd_val < key_q) || ((rd_val == key_q) && (cmp_q < outer_q));
  assign rank_fin = rank_q + IW'(less);
  assign prod = PROD_W'(sum_q) * PROD_W'(DIV5_MUL);

  always_comb begin
    fst_d   = fst_q;
    outer_d = outer_q;
    cmp_d   = cmp_q;
    rank_d  = rank_q;
    key_d   = key_q;
    sum_d   = sum_q;
    div_d   = 1'b0;
    rd_addr = outer_q;
    case (fst_q)
      F_IDLE: begin
        if (ctl_i.start) begin
          outer_d = '0;
          sum_d   = '0;
          fst_d   = F_KEY;
        end
      end
      F_KEY: begin
        rd_addr = outer_q;
        fst_d   = F_KEYW;
      end
      F_KEYW: begin
        key_d   = rd_val;
        rd_addr = '0;
        cmp_d   = '0;
        rank_d  = '0;
        fst_d   = F_SCAN;
      end
      F_SCAN: begin
        rd_addr = (cmp_q == LAST) ? '0 : cmp_q + 1'b1;
        rank_d  = rank_fin;
        cmp_d   = cmp_q + 1'b1;
        if (cmp_q == LAST) begin
          if (rank_fin >= RANK_LO && rank_fin <= RANK_HI) begin
            sum_d = sum_q + SUM_W'(key_q);
          end
          if (outer_q == LAST) begin
            div_d = 1'b1;
            fst_d = F_IDLE;
          end else begin
            outer_d = outer_q + 1'b1;
            fst_d   = F_KEY;
          end
        end
      end
      default: fst_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q   <= F_IDLE;
      valid_q <= '0;
      widx_q  <= '0;
      div_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      fst_q  <= fst_d;
      div_q  <= div_d;
      done_q <= div_q;
      if (ctl_i.wr) begin
        valid_q[widx_q] <= 1'b1;
        widx_q          <= widx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    outer_q <= outer_d;
    cmp_q   <= cmp_d;
    rank_q  <= rank_d;
    key_q   <= key_d;
    sum_q   <= sum_d;
    if (div_q) begin
      value_q <= prod[DIV5_SHIFT +: SAMPLE_W];
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule
`default_nettype wire

FILE: tb/sv/capacitive_touch_sense_filter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacitive_touch_sense_filter_core_test
// Self-checking bench for the touch pad sequencer and its trimmed-mean filter.
// A directed table walks the pad cycle and its corner cases. Randomized
// phases follow, each under its own register setting. Every input transfer
// is run through a local model of the pad. Each result transfer is checked
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module capacitive_touch_sense_filter_core_test;
  import ctsf_pkg::*;

  localparam int unsigned DEPTH       = RING_DEPTH_DEF;
  localparam int unsigned HOLD_CYCLES = 800;   // one long output back-pressure
  localparam int unsigned STALL_LIMIT = 5000;  // hold-off plus a slow filter step
  localparam int unsigned SETTLE      = 300;   // a bit over one filter step
  localparam int unsigned MAX_PRINTS  = 40;

  // Item kinds on the input channel.
  typedef enum bit {
    FN_TICK    = 1'b0,
    FN_CAPTURE = 1'b1
  } pad_func_e;

  // How random capture values are drawn in a phase.
  typedef enum logic [1:0] {
    CAP_UNIFORM = 2'd0,
    CAP_NEAR    = 2'd1,  // around the touch threshold
    CAP_HIGH    = 2'd2   // mostly full scale
  } cap_mode_e;

  typedef enum bit {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    logic        touched;
    logic [15:0] filtered_value;
    logic        pin_floating;
    logic        timer_clear;
    logic        sample_stored;
  } pad_report_t;

  typedef struct packed {
    row_kind_e   kind;
    pad_func_e   fn;
    logic [15:0] cap;
    ctsf_cfg_e   reg_idx;
    logic [15:0] reg_val;
    bit          typed;
    pad_report_t want;
  } dir_row_t;

  typedef struct packed {
    logic [7:0]  discharge;
    logic [7:0]  measure;
    logic [9:0]  period;
    logic [15:0] threshold;
    cap_mode_e   mode;
    int          items;
    int          steady_items;
    bit          hold;
  } pad_setting_t;

  // Results that can be read off directly.
  localparam pad_report_t R_QUIET       = '{1'b0, 16'h0000, 1'b0, 1'b0, 1'b0};
  localparam pad_report_t R_FLOAT       = '{1'b0, 16'h0000, 1'b1, 1'b0, 1'b0};
  localparam pad_report_t R_FLOAT_CLR   = '{1'b0, 16'h0000, 1'b1, 1'b1, 1'b0};
  localparam pad_report_t R_FLOAT_STORE = '{1'b0, 16'h0000, 1'b1, 1'b0, 1'b1};

  // Directed walk, starting from the reset register values
  // (discharge 10, measure 20, period 50, threshold 4400).
  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // capture before any measurement is ignored
    '{ROW_ITEM, FN_CAPTURE, 16'hFFFF, CFG_DISCHARGE, 16'h0000, 1'b1, R_QUIET},
    // start of cycle, then still discharging
    '{ROW_ITEM, FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b1, R_QUIET},
    '{ROW_ITEM, FN_TICK,    16'hFFFF, CFG_DISCHARGE, 16'h0000, 1'b1, R_QUIET},
    // zero tick counts, filter on every tick, threshold at floor
    '{ROW_CFG,  FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    '{ROW_CFG,  FN_TICK,    16'h0000, CFG_MEASURE,   16'h0000, 1'b0, '0},
    '{ROW_CFG,  FN_TICK,    16'h0000, CFG_PERIOD,    16'h0001, 1'b0, '0},
    '{ROW_CFG,  FN_TICK,    16'h0000, CFG_THRESHOLD, 16'h0000, 1'b0, '0},
    // discharge done at once: float and clear timer
    '{ROW_ITEM, FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b1, R_FLOAT_CLR},
    // measurement timeout stores the capture register
    '{ROW_ITEM, FN_TICK,    16'hFFFF, CFG_DISCHARGE, 16'h0000, 1'b1, R_FLOAT_STORE},
    // stray capture, pin keeps floating
    '{ROW_ITEM, FN_CAPTURE, 16'h1234, CFG_DISCHARGE, 16'h0000, 1'b1, R_FLOAT},
    '{ROW_ITEM, FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b1, R_QUIET},
    '{ROW_ITEM, FN_TICK,    16'h5555, CFG_DISCHARGE, 16'h0000, 1'b1, R_FLOAT_CLR},
    // capture while measuring, then a second one that is ignored
    '{ROW_ITEM, FN_CAPTURE, 16'hFFFF, CFG_DISCHARGE, 16'h0000, 1'b1, R_FLOAT_STORE},
    '{ROW_ITEM, FN_CAPTURE, 16'hAAAA, CFG_DISCHARGE, 16'h0000, 1'b1, R_FLOAT},
    '{ROW_ITEM, FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, FN_CAPTURE, 16'h8000, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, FN_CAPTURE, 16'h7FFF, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, FN_TICK,    16'h0001, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    // threshold at ceiling: never touched
    '{ROW_CFG,  FN_TICK,    16'h0000, CFG_THRESHOLD, 16'hFFFF, 1'b0, '0},
    '{ROW_ITEM, FN_TICK,    16'h0000, CFG_DISCHARGE, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, FN_TICK,    16'hFFFF, CFG_DISCHARGE, 16'h0000, 1'b0, '0}
  };

  // Random phases: reset values, minimums, maximums, full-scale samples
  // on both sides of the threshold, zero counts, then a mixed setting with
  // a no-idle stretch and the long output hold-off.
  localparam int PHASES = 6;
  localparam pad_setting_t PLAN [PHASES] = '{
    '{8'd10,  8'd20,  10'd50,   16'd4400,  CAP_NEAR,    200, 0,   1'b0},
    '{8'd1,   8'd1,   10'd1,    16'd0,     CAP_UNIFORM, 200, 0,   1'b0},
    '{8'd255, 8'd255, 10'd1023, 16'hFFFF,  CAP_HIGH,    220, 0,   1'b0},
    '{8'd2,   8'd3,   10'd4,    16'hFFFF,  CAP_HIGH,    200, 0,   1'b0},
    '{8'd0,   8'd0,   10'd0,    16'hFFFE,  CAP_HIGH,    200, 0,   1'b0},
    '{8'd5,   8'd7,   10'd13,   16'd30000, CAP_NEAR,    210, 150, 1'b1}
  };

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ctsf_in_if  in_ch ();
  ctsf_out_if out_ch ();

  capacitive_touch_sense_filter_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Pad model: registers and sequencer state mirrored here.
  // --------------------------------------------------------------------------
  logic [7:0]  pad_discharge;
  logic [7:0]  pad_measure;
  logic [9:0]  pad_period;
  logic [15:0] pad_threshold;

  ctsf_phase_e pad_phase;
  logic [7:0]  pad_phase_ticks;
  logic        pad_measuring;
  logic [9:0]  pad_filter_ticks;
  logic [15:0] pad_ring [DEPTH];
  logic [3:0]  pad_wr_idx;
  logic [15:0] pad_filtered;
  logic        pad_pin_float;

  pad_report_t pad_reports_q [$];  // predictions waiting for their result

  int unsigned mismatches;
  int unsigned stall_cycles;
  bit          steady_mode;  // no idling on either side
  bit          hold_req;     // ask the receiver for its long hold-off
  bit          hold_done;

  always #1 clk_i = ~clk_i;

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t mismatch: %0s", $time, msg);
    end
  endtask

  function automatic void ring_store(logic [15:0] v);
    pad_ring[pad_wr_idx] = v;
    pad_wr_idx = pad_wr_idx + 4'd1;  // wraps at depth 16
  endfunction

  // Mean of the five entries around the middle of a sorted ring copy.
  function automatic logic [15:0] middle_five_mean();
    logic [15:0] s [DEPTH];
    logic [15:0] key;
    logic [18:0] sum;
    int i;
    int j;
    s = pad_ring;
    for (i = 1; i < DEPTH; i++) begin
      key = s[i];
      j = i;
      while (j > 0 && s[j-1] > key) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = key;
    end
    sum = '0;
    for (i = DEPTH / 2 - 2; i <= DEPTH / 2 + 2; i++) sum += 19'(s[i]);
    return 16'(sum / 19'd5);
  endfunction

  function automatic pad_report_t pad_step(pad_func_e fn, logic [15:0] cap);
    pad_report_t r;
    logic tclr;
    logic stored;
    tclr = 1'b0;
    stored = 1'b0;
    if (fn == FN_CAPTURE) begin
      // only a capture inside the measuring window counts; nothing ticks
      if (pad_measuring) begin
        ring_store(cap);
        stored = 1'b1;
        pad_measuring = 1'b0;
        pad_phase = PH_START;
      end
    end else begin
      case (pad_phase)
        PH_START: begin
          pad_phase_ticks = '0;
          pad_pin_float = 1'b0;
          pad_phase = PH_DISCH;
        end
        PH_DISCH: begin
          if (pad_phase_ticks >= pad_discharge) begin
            pad_pin_float = 1'b1;
            tclr = 1'b1;
            pad_phase_ticks = '0;
            pad_measuring = 1'b1;
            pad_phase = PH_MEAS;
          end
        end
        PH_MEAS: begin
          if (pad_phase_ticks >= pad_measure) begin
            ring_store(cap);
            stored = 1'b1;
            pad_measuring = 1'b0;
            pad_phase = PH_START;
          end
        end
        default: begin
          pad_measuring = 1'b0;
          pad_phase = PH_START;
        end
      endcase
      if (pad_phase_ticks != 8'hFF) pad_phase_ticks++;
      if (pad_filter_ticks != 10'h3FF) pad_filter_ticks++;
      if (pad_filter_ticks >= pad_period) begin
        pad_filter_ticks = '0;
        pad_filtered = middle_five_mean();
      end
    end
    r.touched        = pad_filtered > pad_threshold;
    r.filtered_value = pad_filtered;
    r.pin_floating   = pad_pin_float;
    r.timer_clear    = tclr;
    r.sample_stored  = stored;
    return r;
  endfunction

  function automatic logic [15:0] pick_capture(cap_mode_e mode);
    int v;
    case (mode)
      CAP_NEAR: begin
        v = int'(pad_threshold) + int'($urandom_range(3000)) - 1500;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
      end
      CAP_HIGH: begin
        if ($urandom_range(99) < 90) return 16'hFFFF;
        return 16'($urandom_range(65535));
      end
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Valid rises at a clock edge; ready is sampled at the falling
  // edge so the transfer at the next rising edge is known race-free.
  // --------------------------------------------------------------------------
  task automatic send_item(pad_func_e fn, logic [15:0] cap, bit typed,
                           pad_report_t want);
    pad_report_t pred;
    while (!steady_mode && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= fn;
    in_ch.capture_value <= cap;
    @(negedge clk_i);
    while (!in_ch.ready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    // transfer happens at the coming edge; the model steps regardless,
    // a typed row only overrides what is checked
    pred = pad_step(fn, cap);
    pad_reports_q.push_back(typed ? want : pred);
    @(posedge clk_i);
  endtask

  // Registers change only with nothing in flight.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pad_reports_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic program_reg(ctsf_cfg_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_DISCHARGE: pad_discharge = val[7:0];
      CFG_MEASURE:   pad_measure   = val[7:0];
      CFG_PERIOD:    pad_period    = val[9:0];
      CFG_THRESHOLD: pad_threshold = val;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Output side: random ready, one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_ch.ready <= steady_mode || ($urandom_range(99) >= 32);
    end
  end

  // Result checker and watchdog, both on the falling edge.
  always @(negedge clk_i) begin
    pad_report_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pad_reports_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending, filtered %h",
                                  out_ch.filtered_value));
        end else begin
          want = pad_reports_q.pop_front();
          if (out_ch.touched !== want.touched)
            flag_mismatch($sformatf("touched got %b want %b",
                                    out_ch.touched, want.touched));
          if (out_ch.filtered_value !== want.filtered_value)
            flag_mismatch($sformatf("filtered_value got %h want %h",
                                    out_ch.filtered_value, want.filtered_value));
          if (out_ch.pin_floating !== want.pin_floating)
            flag_mismatch($sformatf("pin_floating got %b want %b",
                                    out_ch.pin_floating, want.pin_floating));
          if (out_ch.timer_clear !== want.timer_clear)
            flag_mismatch($sformatf("timer_clear got %b want %b",
                                    out_ch.timer_clear, want.timer_clear));
          if (out_ch.sample_stored !== want.sample_stored)
            flag_mismatch($sformatf("sample_stored got %b want %b",
                                    out_ch.sample_stored, want.sample_stored));
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    pad_func_e fn;
    int ph;
    int row;
    int served;
    pad_setting_t s;

    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_data_i          = '0;
    in_ch.valid         = 1'b0;
    in_ch.func          = 1'b0;
    in_ch.capture_value = '0;
    mismatches          = 0;
    stall_cycles        = 0;
    steady_mode         = 1'b0;
    hold_req            = 1'b0;
    hold_done           = 1'b0;

    // model reset state
    pad_discharge    = DISCHARGE_RST;
    pad_measure      = MEASURE_RST;
    pad_period       = PERIOD_RST;
    pad_threshold    = THRESHOLD_RST;
    pad_phase        = PH_START;
    pad_phase_ticks  = '0;
    pad_measuring    = 1'b0;
    pad_filter_ticks = '0;
    pad_wr_idx       = '0;
    pad_filtered     = '0;
    pad_pin_float    = 1'b0;
    for (row = 0; row < DEPTH; row++) pad_ring[row] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk
    for (row = 0; row < DIR_ROWS; row++) begin
      if (DIR_TAB[row].kind == ROW_CFG) begin
        wait_idle();
        program_reg(DIR_TAB[row].reg_idx, DIR_TAB[row].reg_val);
      end else begin
        send_item(DIR_TAB[row].fn, DIR_TAB[row].cap, DIR_TAB[row].typed,
                  DIR_TAB[row].want);
      end
    end

    // random phases; mostly ticks, captures biased into the measuring window
    for (ph = 0; ph < PHASES; ph++) begin
      s = PLAN[ph];
      wait_idle();
      program_reg(CFG_DISCHARGE, {8'h00, s.discharge});
      program_reg(CFG_MEASURE,   {8'h00, s.measure});
      program_reg(CFG_PERIOD,    {6'h00, s.period});
      program_reg(CFG_THRESHOLD, s.threshold);
      served = 0;
      while (served < s.items) begin
        fn = ($urandom_range(99) < (pad_measuring ? 40 : 8)) ? FN_CAPTURE : FN_TICK;
        // stray captures are ignored by the block and do not count
        if (fn == FN_TICK || pad_measuring) served++;
        steady_mode = served <= s.steady_items;
        // sender keeps offering while the receiver holds off
        if (s.hold && served == 1) hold_req = 1'b1;
        send_item(fn, pick_capture(s.mode), 1'b0, '0);
      end
      steady_mode = 1'b0;
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ctsf_pkg.sv
hw/rtl/ctsf_if.sv
hw/rtl/ctsf_rank_filter.sv
hw/rtl/capacitive_touch_sense_filter_core.sv
tb/sv/capacitive_touch_sense_filter_core_test.sv
